/* sv/modexp_pkg.sv */
// ----------------------------------------------------------------------------
// modexp_pkg: shared widths and constants for modular exponentiation
// Operand widths, the modulus reset value and the sequencer state codes.
// ----------------------------------------------------------------------------
`default_nettype none
package modexp_pkg;
  localparam int unsigned ModW   = 31;
  localparam int unsigned FieldW = 63;
  localparam logic [ModW-1:0] ModulusReset = 31'd1000000007;

  // sequencer state codes
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRed  = 3'd1;
  localparam logic [2:0] StChk  = 3'd2;
  localparam logic [2:0] StMul  = 3'd3;
  localparam logic [2:0] StDone = 3'd4;

  typedef logic [ModW-1:0] mod_t;
endpackage
`default_nettype wire

/* sv/modular_exponentiation_top.sv */
// ----------------------------------------------------------------------------
// modular_exponentiation_top: base to the exponent modulo a register
// Right-to-left square and multiply on two bit-serial multipliers.
// ----------------------------------------------------------------------------
// channel  dir  handshake                  payload
// s_axis   in   s_axis_tvalid/tready       tdata: base_value, exponent
// m_axis   out  m_axis_tvalid/tready       tdata: power_result
// cfg      in   cfg_valid_i/cfg_ready_o    cfg_data_i: modulus
//
// per word after acceptance: the base reduction, then one square and multiply
// pass per exponent bit up to the highest set bit, then the final check and
// done steps; the number of exponent bits is at most min(EXP_WIDTH, 63).
// the square and the multiply run side by side.
// reset sets the modulus to 1000000007; no clearing pass.
// one word in flight; the next is taken while the result waits, and its own
// result is held back until the output register has emptied.
// ----------------------------------------------------------------------------
`default_nettype none
module modular_exponentiation_top #(
  parameter int unsigned EXP_WIDTH = 64
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  input  wire  [127:0] s_axis_tdata,   // [62:0] base_value, [125:63] exponent
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  output logic [31:0]  m_axis_tdata,   // [30:0] power_result
  input  wire          cfg_valid_i,
  output logic         cfg_ready_o,
  input  wire  [30:0]  cfg_data_i      // modulus
);
  import modexp_pkg::*;

  localparam int unsigned EW   = (EXP_WIDTH < FieldW) ? EXP_WIDTH : FieldW;
  localparam int unsigned RedW = $clog2(FieldW);

  logic [2:0]        st_q;
  mod_t              mod_q;
  mod_t              r_q, b_q;
  logic [EW-1:0]     e_q;
  logic [FieldW-1:0] sh_q;
  logic [RedW-1:0]   rcnt_q;
  logic              ovld_q;
  mod_t              out_q;
  logic              start;
  mod_t              prod_r, prod_b;
  logic              done_r, done_b;
  logic [ModW:0]     red_t, red_s;
  logic              in_acc;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (st_q == StIdle);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign start         = (st_q == StChk) && (e_q != '0);

  // base reduction step: shift one base bit into the remainder
  always_comb begin
    red_t = {r_q, sh_q[FieldW-1]};
    red_s = (red_t >= {1'b0, mod_q}) ? red_t - {1'b0, mod_q} : red_t;
  end

  // modulus register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= ModulusReset;
    end else if (cfg_valid_i) begin
      mod_q <= cfg_data_i;
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= StIdle;
      ovld_q <= 1'b0;
      rcnt_q <= '0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) ovld_q <= 1'b0;
      case (st_q)
        StIdle: begin
          if (in_acc) begin
            rcnt_q <= '0;
            st_q   <= (mod_q < ModW'(2)) ? StDone : StRed;
          end
        end
        StRed: begin
          rcnt_q <= rcnt_q + 1'b1;
          if (rcnt_q == RedW'(FieldW - 1)) st_q <= StChk;
        end
        StChk: begin
          st_q <= (e_q == '0) ? StDone : StMul;
        end
        StMul: begin
          if (done_r && done_b) st_q <= StChk;
        end
        StDone: begin
          if (!ovld_q) begin
            ovld_q <= 1'b1;
            st_q   <= StIdle;
          end
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (st_q)
      StIdle: begin
        if (in_acc) begin
          sh_q <= s_axis_tdata[FieldW-1:0];
          e_q  <= s_axis_tdata[FieldW +: EW];
          r_q  <= '0;
          b_q  <= '0;
        end
      end
      StRed: begin
        sh_q <= {sh_q[FieldW-2:0], 1'b0};
        if (rcnt_q == RedW'(FieldW - 1)) begin
          b_q <= red_s[ModW-1:0];
          r_q <= ModW'(1);
        end else begin
          r_q <= red_s[ModW-1:0];
        end
      end
      StMul: begin
        if (done_r && done_b) begin
          if (e_q[0]) r_q <= prod_r;
          b_q <= prod_b;
          e_q <= e_q >> 1;
        end
      end
      StDone: begin
        if (!ovld_q) out_q <= (mod_q < ModW'(2)) ? '0 : r_q;
      end
      default: begin
      end
    endcase
  end

  // running result times base
  modexp_mulser u_mul_r (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .a_i    (r_q),
    .b_i    (b_q),
    .m_i    (mod_q),
    .prod_o (prod_r),
    .done_o (done_r)
  );

  // base squared
  modexp_mulser u_mul_b (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .a_i    (b_q),
    .b_i    (b_q),
    .m_i    (mod_q),
    .prod_o (prod_b),
    .done_o (done_b)
  );

  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = {1'b0, out_q};
endmodule
`default_nettype wire

/* sv/modexp_mulser.sv */
// ----------------------------------------------------------------------------
// modexp_mulser: bit-serial modular multiplier
// Interleaved shift-add: one multiplier bit per cycle, msb first.
// ----------------------------------------------------------------------------
`default_nettype none
module modexp_mulser (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   start_i,
  input  modexp_pkg::mod_t      a_i,
  input  modexp_pkg::mod_t      b_i,
  input  modexp_pkg::mod_t      m_i,
  output modexp_pkg::mod_t      prod_o,
  output logic                  done_o
);
  import modexp_pkg::*;

  localparam int unsigned CntW = $clog2(ModW);

  mod_t            acc_q, acc_d;
  mod_t            a_q;
  mod_t            b_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q;
  logic            done_q;
  logic [ModW:0]   dbl, dbl_r, sum, sum_r;

  // one step: acc = 2*acc + bit*a, both reduced by a single subtract
  always_comb begin
    dbl   = {acc_q, 1'b0};
    dbl_r = (dbl >= {1'b0, m_i}) ? dbl - {1'b0, m_i} : dbl;
    sum   = dbl_r + (b_q[ModW-1] ? {1'b0, a_q} : '0);
    sum_r = (sum >= {1'b0, m_i}) ? sum - {1'b0, m_i} : sum;
    acc_d = sum_r[ModW-1:0];
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= !start_i && busy_q && (cnt_q == CntW'(ModW - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(ModW - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // operand and accumulator shift registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      a_q   <= a_i;
      b_q   <= b_i;
    end else if (busy_q) begin
      acc_q <= acc_d;
      b_q   <= {b_q[ModW-2:0], 1'b0};
    end
  end

  assign prod_o = acc_q;
  assign done_o = done_q;
endmodule
`default_nettype wire

/* tb/sv/modexp_checker.sv */
// ----------------------------------------------------------------------------
// modexp_checker: result predictor and scoreboard for modular exponentiation
// Watches the input, result and modulus channels, computes each expected
// power from its own copy of the modulus and compares every result word.
// ----------------------------------------------------------------------------
module modexp_checker
  import modexp_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // [62:0] base_value, [125:63] exponent
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [31:0]  m_axis_tdata,   // [30:0] power_result
  input  logic         cfg_valid_i,
  input  logic         cfg_ready_o,
  input  logic [30:0]  cfg_data_i,
  output int           fail_count_o,
  output int           pending_o
);

  mod_t modulus_q;
  mod_t power_queue[$];

  // right-to-left square and multiply, modulus below two gives zero
  function automatic mod_t power_mod(logic [FieldW-1:0] base_v,
                                     logic [FieldW-1:0] exp_v, mod_t m);
    logic [63:0]       acc;
    logic [63:0]       sq;
    logic [63:0]       mm;
    logic [FieldW-1:0] e;
    if (m < 2) return '0;
    mm  = 64'(m);
    sq  = 64'(base_v) % mm;
    acc = 64'd1;
    e   = exp_v;
    while (e != 0) begin
      if (e[0]) acc = (acc * sq) % mm;
      sq = (sq * sq) % mm;
      e  = e >> 1;
    end
    return acc[ModW-1:0];
  endfunction

  assign pending_o = power_queue.size();

  always @(posedge clk_i or negedge rst_ni) begin
    mod_t want;
    if (!rst_ni) begin
      modulus_q    <= ModulusReset;
      fail_count_o <= 0;
      power_queue.delete();
    end else begin
      // modulus register write
      if (cfg_valid_i && cfg_ready_o) modulus_q <= cfg_data_i;
      // compare result word against oldest expectation
      if (m_axis_tvalid && m_axis_tready) begin
        if (power_queue.size() == 0) begin
          $display("%0t: unexpected result word, actual %0d", $time,
                   m_axis_tdata[30:0]);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = power_queue.pop_front();
          if (m_axis_tdata[30:0] !== want) begin
            $display("%0t: power_result mismatch, expected %0d actual %0d",
                     $time, want, m_axis_tdata[30:0]);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      // predict for each accepted input word
      if (s_axis_tvalid && s_axis_tready)
        power_queue.insert(power_queue.size(),
                           power_mod(s_axis_tdata[62:0], s_axis_tdata[125:63],
                                     modulus_q));
    end
  end

endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for modular_exponentiation_top
// Directed corner words, then random phases under several modulus settings
// with bursty input, a stalling receiver and a separate scoreboard.
// ----------------------------------------------------------------------------
module testbench;
  import modexp_pkg::*;

  localparam int IdleLimit = 60000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [31:0]  m_axis_tdata;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [30:0]  cfg_data_i = '0;
  int           fail_count;
  int           pending;
  int           idle_cycles = 0;
  int           burst_left = 0;
  int           words_sent = 0;
  int           moduli_used = 0;
  int           stall_mode = 0;
  int           stall_cnt = 0;

  always #2 clk_i = ~clk_i;

  modular_exponentiation_top i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  modexp_checker i_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // receiver stall pattern: always ready, random ready or mostly stalled
  always @(posedge clk_i) begin
    stall_cnt <= stall_cnt + 1;
    if (stall_cnt % 300 == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: begin
        m_axis_tready <= 1'b1;
      end
      1: begin
        m_axis_tready <= $urandom_range(0, 1);
      end
      default: begin
        m_axis_tready <= ($urandom_range(0, 5) == 0);
      end
    endcase
  end

  // watchdog on cycles with no word moving anywhere
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending != 0) @(posedge clk_i);
  endtask

  // send one word, bursts with random gaps between them
  task automatic send_word(logic [62:0] base_v, logic [62:0] exp_v);
    int gap;
    s_axis_tdata  <= {2'b00, exp_v, base_v};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      gap = $urandom_range(0, 10);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // modulus write while the block is idle
  task automatic write_modulus(mod_t m);
    s_axis_tvalid <= 1'b0;
    wait_drained();
    @(posedge clk_i);
    cfg_data_i  <= m;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    moduli_used++;
  endtask

  function automatic logic [62:0] rand63();
    return {$urandom(), $urandom()};
  endfunction

  // mostly short exponents, a few full width
  function automatic logic [62:0] rand_exp();
    logic [62:0] e;
    int          w;
    e = rand63();
    if ($urandom_range(0, 19) == 0) return e;
    w = $urandom_range(0, 9);
    return (w == 0) ? 63'd0 : (e & ((63'd1 << w) - 63'd1));
  endfunction

  localparam logic [62:0] FieldMax = {63{1'b1}};

  initial begin
    mod_t m;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed words at the reset modulus
    send_word(63'd0, 63'd0);
    send_word(FieldMax, 63'd0);
    send_word(63'd0, 63'd5);
    send_word(FieldMax, FieldMax);
    send_word(63'd1, FieldMax);
    send_word(63'd1000000006, 63'd2);
    send_word(63'd1000000007, 63'd3);
    send_word(63'd2, 63'd1000000006);
    send_word(63'd12345, 63'd1);
    // modulus extremes, including the degenerate zero and one
    write_modulus(31'h7fffffff);
    send_word(FieldMax, FieldMax);
    send_word(63'h7ffffffe, 63'd2);
    send_word(63'd3, 63'h5555_5555_5555_5555);
    write_modulus(31'd2);
    send_word(63'd3, 63'd7);
    send_word(63'd4, 63'd0);
    write_modulus(31'd0);
    send_word(63'd5, 63'd0);
    send_word(FieldMax, 63'd9);
    write_modulus(31'd1);
    send_word(63'd7, 63'd0);
    send_word(63'd7, 63'd3);
    write_modulus(31'd3);
    send_word(63'd2, 63'h2aaa_aaaa_aaaa_aaaa);
    send_word(63'd9, FieldMax);

    // random phases under changing modulus
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: m = ModulusReset;
        3: m = 31'h7fffffff;
        6: m = 31'd2;
        8: m = ($urandom_range(0, 1) == 0) ? 31'd0 : 31'd1;
        default: m = ($urandom_range(0, 1) == 0) ? 31'($urandom_range(2, 1000))
                                                 : 31'($urandom_range(2, 32'h7fffffff));
      endcase
      write_modulus(m);
      for (int k = 0; k < 163; k++) begin
        send_word(rand63(), rand_exp());
        // hold off until every result has come back
        if (k == 80) begin
          s_axis_tvalid <= 1'b0;
          wait_drained();
        end
      end
    end

    s_axis_tvalid <= 1'b0;
    wait_drained();
    repeat (2200) @(posedge clk_i);
    $display("covered %0d input words over %0d modulus writes,", words_sent, moduli_used);
    $display("corner bases, zero and full width exponents, degenerate moduli");
    if (fail_count == 0 && pending == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
